// File: src/fvpsg_pkg.sv
// Shared types, codes and constants of the four-voice sound generator.
`default_nettype none
package fvpsg_pkg;

    localparam int RATE_W     = 18;
    localparam int DIVIDEND_W = 52;
    localparam int DIVISOR_W  = 30;
    localparam int QUO_W      = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [RATE_W-1:0]    RATE_RESET = 18'd32768;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = 6'd52;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_BEGIN  = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BB_SETUP,
        ST_DIV_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BB_FLAG,
        ST_SMP_STEP,
        ST_SMP_SUM,
        ST_SMP_MUL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_SQ0,
        DIV_SQ1,
        DIV_WAVE,
        DIV_NOISE
    } div_sel_t;

    typedef struct packed {
        logic     wr;
        logic     capture;
        logic     setup;
        logic     div_load;
        logic     div_start;
        logic     div_store;
        div_sel_t sel;
        logic     flag;
        logic     step;
        logic     sum;
        logic     mul;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic active;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: src/fvpsg_div.sv
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
`default_nettype none
module fvpsg_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [fvpsg_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [fvpsg_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                     done,
    output logic [fvpsg_pkg::QUO_W-1:0]              quotient
);

    logic [fvpsg_pkg::DIVIDEND_W-1:0] num_reg;
    logic [fvpsg_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [fvpsg_pkg::QUO_W-1:0]      quo_reg;
    logic [fvpsg_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [fvpsg_pkg::DIVISOR_W:0]    rem_sh;
    logic                             ge;
    logic [fvpsg_pkg::DIVISOR_W:0]    rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[fvpsg_pkg::DIVIDEND_W-1]};
        ge      = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= fvpsg_pkg::DIV_STEPS;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[fvpsg_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[fvpsg_pkg::DIVISOR_W-1:0]
                          : rem_sh[fvpsg_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[fvpsg_pkg::QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg && !busy_reg)
        else $error("divider done longer than one cycle");

endmodule
`default_nettype wire

// File: src/fvpsg_dp.sv
// Datapath: register window, voice state, increment divider, mixer and output beat.
`default_nettype none
module fvpsg_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fvpsg_pkg::cmd_t               cmd,
    output fvpsg_pkg::sts_t                    sts,
    input  wire logic [15:0]                   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic [fvpsg_pkg::RATE_W-1:0]  cfg_data
);

    localparam int CTL_DEPTH = 48;
    localparam logic [5:0] OFS_SQ0_HDR  = 6'h02;
    localparam logic [5:0] OFS_SQ0_ENV  = 6'h03;
    localparam logic [5:0] OFS_SQ0_CTL  = 6'h04;
    localparam logic [5:0] OFS_SQ1_HDR  = 6'h08;
    localparam logic [5:0] OFS_SQ1_ENV  = 6'h09;
    localparam logic [5:0] OFS_SQ1_CTL  = 6'h0C;
    localparam logic [5:0] OFS_WAVE_EN  = 6'h10;
    localparam logic [5:0] OFS_WAVE_VOL = 6'h13;
    localparam logic [5:0] OFS_WAVE_CTL = 6'h14;
    localparam logic [5:0] OFS_NZ_ENV   = 6'h19;
    localparam logic [5:0] OFS_NZ_CTL   = 6'h1C;
    localparam logic [5:0] OFS_MIX      = 6'h20;
    localparam logic [5:0] OFS_RATIO    = 6'h22;
    localparam logic [5:0] OFS_MASTER   = 6'h24;
    localparam logic [13:0] UNIT_SCALE  = 14'd300;
    localparam logic [2:0] VOL_MUTE     = 3'd0;
    localparam logic [2:0] VOL_FULL     = 3'd1;
    localparam logic [2:0] VOL_HALF     = 3'd2;
    localparam logic [2:0] VOL_3Q       = 3'd4;

    typedef struct packed {
        logic [3:0]  lvl;
        logic [15:0] cnt;
    } env_t;

    function automatic env_t env_step(logic [3:0] lvl, logic [15:0] per, logic up,
                                      logic [15:0] cnt);
        env_t r;
        r.lvl = lvl;
        r.cnt = cnt;
        if (per != 16'd0)
        begin
            r.cnt = cnt - 16'd1;
            if (r.cnt == 16'd0)
            begin
                r.cnt = per;
                if (up)
                begin
                    if (lvl != 4'd15) r.lvl = lvl + 4'd1;
                end
                else if (lvl != 4'd0)
                begin
                    r.lvl = lvl - 4'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] env_period(logic [fvpsg_pkg::RATE_W-1:0] rate,
                                               logic [2:0] stp);
        logic [20:0] prod;
        prod = 21'(rate) * 21'(stp);
        return {1'b0, prod[20:6]};
    endfunction

    function automatic logic [31:0] duty_lim(logic [1:0] d);
        logic [31:0] r;
        unique case (d)
            2'd0: r = 32'h2000_0000;
            2'd1: r = 32'h4000_0000;
            2'd2: r = 32'h8000_0000;
            default: r = 32'hC000_0000;
        endcase
        return r;
    endfunction

    function automatic logic [20:0] noise_base(logic [2:0] r);
        logic [20:0] b;
        unique case (r)
            3'd0: b = 21'd1048576;
            3'd1: b = 21'd524288;
            3'd2: b = 21'd262144;
            3'd3: b = 21'd174762;
            3'd4: b = 21'd131072;
            3'd5: b = 21'd104857;
            3'd6: b = 21'd87381;
            default: b = 21'd74898;
        endcase
        return b;
    endfunction

    function automatic logic [13:0] scale_of(logic [2:0] v, logic [1:0] ratio);
        logic [13:0] base;
        logic [13:0] r;
        base = UNIT_SCALE * {10'd0, {1'b0, v} + 4'd1};
        unique case (ratio)
            2'd0: r = base;
            2'd1: r = base << 1;
            default: r = base << 2;
        endcase
        return r;
    endfunction

    function automatic logic signed [7:0] sq_amp(logic [31:0] ph, logic [31:0] inc,
                                                 logic [3:0] lvl, logic [1:0] duty);
        logic signed [7:0] a;
        a = 8'sd0;
        if (inc != 32'd0 && lvl != 4'd0)
            a = (ph < duty_lim(duty)) ? $signed({4'd0, lvl}) : -$signed({4'd0, lvl});
        return a;
    endfunction

    // register window
    logic [7:0] ctl_reg [CTL_DEPTH];
    logic [7:0] wave_mem_reg [16];
    logic [fvpsg_pkg::RATE_W-1:0] rate_reg;

    // voice state
    logic [31:0] sq_phase_reg [2];
    logic [31:0] sq_inc_reg [2];
    logic [1:0]  sq_duty_reg [2];
    logic [3:0]  sq_level_reg [2];
    logic        sq_up_reg [2];
    logic [15:0] sq_per_reg [2];
    logic [15:0] sq_cnt_reg [2];
    logic [16:0] sq_prev_ctl_reg [2];
    logic [8:0]  sq_prev_env_reg [2];
    logic [31:0] wave_phase_reg, wave_inc_reg;
    logic [2:0]  wave_mode_reg;
    logic        wave_on_reg;
    logic [16:0] wave_prev_ctl_reg;
    logic [31:0] nz_phase_reg, nz_inc_reg;
    logic [14:0] nz_lfsr_reg;
    logic        nz_short_reg;
    logic [3:0]  nz_level_reg;
    logic        nz_up_reg;
    logic [15:0] nz_per_reg, nz_cnt_reg;
    logic [16:0] nz_prev_ctl_reg;
    logic [8:0]  nz_prev_env_reg;
    logic [3:0]  pan_l_reg, pan_r_reg;
    logic        master_on_reg;
    logic [13:0] l_scale_reg, r_scale_reg;
    logic        any_voice_on_reg;

    // working registers
    logic [fvpsg_pkg::DIVIDEND_W-1:0] div_num_reg;
    logic [fvpsg_pkg::DIVISOR_W-1:0]  div_den_reg;
    logic signed [7:0]  l_sum_reg, r_sum_reg;
    logic signed [14:0] l_res_reg, r_res_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic        div_done;
    logic [31:0] div_quo;

    // decoded window fields
    logic [15:0] sq_hdr [2];
    logic [15:0] sq_ctl [2];
    logic [15:0] wave_ctl, nz_ctl, mix;
    logic [7:0]  nz_env;
    logic [15:0] ctl_sel;
    logic [11:0] span;
    logic [20:0] fhz_sh;
    logic [19:0] fhz;
    logic [4:0]  nz_shift;

    // sample step next values
    env_t        sq_env_n [2];
    env_t        nz_env_n;
    logic [32:0] nz_sum;
    logic        nz_bit;
    logic [14:0] nz_lfsr_n;

    // mix terms
    logic signed [7:0]  sa [2];
    logic [7:0]         wbyte;
    logic [3:0]         wnib;
    logic signed [7:0]  wa, w3, wamp, namp;
    logic signed [7:0]  l_sum, r_sum;
    logic signed [22:0] l_prod, r_prod;
    logic [3:0]         pan;

    assign sq_hdr[0] = {ctl_reg[OFS_SQ0_ENV], ctl_reg[OFS_SQ0_HDR]};
    assign sq_hdr[1] = {ctl_reg[OFS_SQ1_ENV], ctl_reg[OFS_SQ1_HDR]};
    assign sq_ctl[0] = {ctl_reg[OFS_SQ0_CTL + 6'd1], ctl_reg[OFS_SQ0_CTL]};
    assign sq_ctl[1] = {ctl_reg[OFS_SQ1_CTL + 6'd1], ctl_reg[OFS_SQ1_CTL]};
    assign wave_ctl  = {ctl_reg[OFS_WAVE_CTL + 6'd1], ctl_reg[OFS_WAVE_CTL]};
    assign nz_ctl    = {ctl_reg[OFS_NZ_CTL + 6'd1], ctl_reg[OFS_NZ_CTL]};
    assign nz_env    = ctl_reg[OFS_NZ_ENV];
    assign mix       = {ctl_reg[OFS_MIX + 6'd1], ctl_reg[OFS_MIX]};
    assign pan       = pan_l_reg | pan_r_reg;

    always_comb
    begin
        unique case (cmd.sel)
            fvpsg_pkg::DIV_SQ0:  ctl_sel = sq_ctl[0];
            fvpsg_pkg::DIV_SQ1:  ctl_sel = sq_ctl[1];
            fvpsg_pkg::DIV_WAVE: ctl_sel = wave_ctl;
            default:             ctl_sel = nz_ctl;
        endcase
        span     = 12'd2048 - {1'b0, ctl_sel[10:0]};
        nz_shift = {1'b0, nz_ctl[7:4]} + 5'd1;
        fhz_sh   = noise_base(nz_ctl[2:0]) >> nz_shift;
        fhz      = (fhz_sh == 21'd0) ? 20'd1 : fhz_sh[19:0];
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            sq_env_n[i] = env_step(sq_level_reg[i], sq_per_reg[i], sq_up_reg[i],
                                   sq_cnt_reg[i]);
        nz_env_n  = env_step(nz_level_reg, nz_per_reg, nz_up_reg, nz_cnt_reg);
        nz_sum    = {1'b0, nz_phase_reg} + {1'b0, nz_inc_reg};
        nz_bit    = nz_lfsr_reg[0] ^ nz_lfsr_reg[1];
        nz_lfsr_n = {nz_bit, nz_lfsr_reg[14:1]};
        if (nz_short_reg) nz_lfsr_n[6] = nz_bit;
        if (!nz_sum[32]) nz_lfsr_n = nz_lfsr_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            sa[i] = sq_amp(sq_phase_reg[i], sq_inc_reg[i], sq_level_reg[i], sq_duty_reg[i]);
        wbyte = wave_mem_reg[wave_phase_reg[31:28]];
        wnib  = wave_phase_reg[27] ? wbyte[3:0] : wbyte[7:4];
        wa    = $signed({4'd0, wnib}) - 8'sd8;
        w3    = wa * 8'sd3;
        unique case (wave_mode_reg)
            VOL_3Q:   wamp = w3 >>> 2;
            VOL_FULL: wamp = wa;
            VOL_HALF: wamp = wa >>> 1;
            default:  wamp = wa >>> 2;
        endcase
        if (!(wave_on_reg && wave_inc_reg != 32'd0 && wave_mode_reg != VOL_MUTE))
            wamp = 8'sd0;
        namp = nz_lfsr_reg[0] ? -$signed({4'd0, nz_level_reg}) : $signed({4'd0, nz_level_reg});
        l_sum = 8'sd0;
        r_sum = 8'sd0;
        for (int i = 0; i < 2; i++)
        begin
            if (pan_l_reg[i]) l_sum = l_sum + sa[i];
            if (pan_r_reg[i]) r_sum = r_sum + sa[i];
        end
        if (pan_l_reg[2]) l_sum = l_sum + wamp;
        if (pan_r_reg[2]) r_sum = r_sum + wamp;
        if (pan_l_reg[3]) l_sum = l_sum + namp;
        if (pan_r_reg[3]) r_sum = r_sum + namp;
        l_prod = 23'(l_sum_reg) * $signed({9'd0, l_scale_reg});
        r_prod = 23'(r_sum_reg) * $signed({9'd0, r_scale_reg});
    end

    // configuration and window writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= fvpsg_pkg::RATE_RESET;
            for (int i = 0; i < CTL_DEPTH; i++) ctl_reg[i] <= 8'd0;
            for (int i = 0; i < 16; i++) wave_mem_reg[i] <= 8'd0;
        end
        else
        begin
            if (cfg_valid) rate_reg <= cfg_data;
            if (cmd.wr)
            begin
                if (s_tdata[5:4] == 2'b11) wave_mem_reg[s_tdata[3:0]] <= s_tdata[13:6];
                else ctl_reg[s_tdata[5:0]] <= s_tdata[13:6];
            end
        end
    end

    // voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sq_phase_reg[i]    <= '0;
                sq_inc_reg[i]      <= '0;
                sq_duty_reg[i]     <= '0;
                sq_level_reg[i]    <= '0;
                sq_up_reg[i]       <= 1'b0;
                sq_per_reg[i]      <= '0;
                sq_cnt_reg[i]      <= '0;
                sq_prev_ctl_reg[i] <= '1;
                sq_prev_env_reg[i] <= '1;
            end
            wave_phase_reg    <= '0;
            wave_inc_reg      <= '0;
            wave_mode_reg     <= VOL_MUTE;
            wave_on_reg       <= 1'b0;
            wave_prev_ctl_reg <= '1;
            nz_phase_reg      <= '0;
            nz_inc_reg        <= '0;
            nz_lfsr_reg       <= '1;
            nz_short_reg      <= 1'b0;
            nz_level_reg      <= '0;
            nz_up_reg         <= 1'b0;
            nz_per_reg        <= '0;
            nz_cnt_reg        <= '0;
            nz_prev_ctl_reg   <= '1;
            nz_prev_env_reg   <= '1;
            pan_l_reg         <= '0;
            pan_r_reg         <= '0;
            master_on_reg     <= 1'b0;
            l_scale_reg       <= '0;
            r_scale_reg       <= '0;
            any_voice_on_reg  <= 1'b0;
        end
        else if (cmd.setup)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sq_duty_reg[i] <= sq_hdr[i][7:6];
                if ({1'b0, sq_hdr[i][15:8]} != sq_prev_env_reg[i])
                begin
                    sq_prev_env_reg[i] <= {1'b0, sq_hdr[i][15:8]};
                    sq_level_reg[i]    <= sq_hdr[i][15:12];
                    sq_up_reg[i]       <= sq_hdr[i][11];
                    sq_per_reg[i]      <= env_period(rate_reg, sq_hdr[i][10:8]);
                    sq_cnt_reg[i]      <= env_period(rate_reg, sq_hdr[i][10:8]);
                end
                if ({1'b0, sq_ctl[i]} != sq_prev_ctl_reg[i])
                begin
                    sq_prev_ctl_reg[i] <= {1'b0, sq_ctl[i]};
                    if (sq_ctl[i][15]) sq_phase_reg[i] <= '0;
                end
            end
            wave_on_reg   <= ctl_reg[OFS_WAVE_EN][7];
            wave_mode_reg <= ctl_reg[OFS_WAVE_VOL][7] ? VOL_3Q
                                                      : {1'b0, ctl_reg[OFS_WAVE_VOL][6:5]};
            if ({1'b0, wave_ctl} != wave_prev_ctl_reg)
            begin
                wave_prev_ctl_reg <= {1'b0, wave_ctl};
                if (wave_ctl[15]) wave_phase_reg <= '0;
            end
            nz_short_reg <= nz_ctl[3];
            if ({1'b0, nz_env} != nz_prev_env_reg)
            begin
                nz_prev_env_reg <= {1'b0, nz_env};
                nz_level_reg    <= nz_env[7:4];
                nz_up_reg       <= nz_env[3];
                nz_per_reg      <= env_period(rate_reg, nz_env[2:0]);
                nz_cnt_reg      <= env_period(rate_reg, nz_env[2:0]);
            end
            if ({1'b0, nz_ctl} != nz_prev_ctl_reg)
            begin
                nz_prev_ctl_reg <= {1'b0, nz_ctl};
                if (nz_ctl[15]) nz_lfsr_reg <= '1;
            end
            master_on_reg <= ctl_reg[OFS_MASTER][7];
            pan_r_reg     <= mix[11:8];
            pan_l_reg     <= mix[15:12];
            l_scale_reg   <= scale_of(mix[6:4], ctl_reg[OFS_RATIO][1:0]);
            r_scale_reg   <= scale_of(mix[2:0], ctl_reg[OFS_RATIO][1:0]);
        end
        else if (cmd.div_store)
        begin
            unique case (cmd.sel)
                fvpsg_pkg::DIV_SQ0:  sq_inc_reg[0] <= div_quo;
                fvpsg_pkg::DIV_SQ1:  sq_inc_reg[1] <= div_quo;
                fvpsg_pkg::DIV_WAVE: wave_inc_reg  <= div_quo;
                default:             nz_inc_reg    <= div_quo;
            endcase
        end
        else if (cmd.flag)
        begin
            any_voice_on_reg <= master_on_reg &&
                ((pan[0] && sq_inc_reg[0] != 32'd0 && sq_level_reg[0] != 4'd0) ||
                 (pan[1] && sq_inc_reg[1] != 32'd0 && sq_level_reg[1] != 4'd0) ||
                 (wave_on_reg && pan[2] && wave_inc_reg != 32'd0 &&
                  wave_mode_reg != VOL_MUTE) ||
                 (pan[3] && nz_inc_reg != 32'd0 && nz_level_reg != 4'd0));
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sq_phase_reg[i] <= sq_phase_reg[i] + sq_inc_reg[i];
                sq_level_reg[i] <= sq_env_n[i].lvl;
                sq_cnt_reg[i]   <= sq_env_n[i].cnt;
            end
            wave_phase_reg <= wave_phase_reg + wave_inc_reg;
            nz_level_reg   <= nz_env_n.lvl;
            nz_cnt_reg     <= nz_env_n.cnt;
            nz_phase_reg   <= nz_sum[31:0];
            nz_lfsr_reg    <= nz_lfsr_n;
        end
    end

    // divider operands and mix results
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            unique case (cmd.sel)
                fvpsg_pkg::DIV_SQ0, fvpsg_pkg::DIV_SQ1:
                begin
                    div_num_reg <= 52'd1 << 49;
                    div_den_reg <= 30'(span) * 30'(rate_reg);
                end
                fvpsg_pkg::DIV_WAVE:
                begin
                    div_num_reg <= 52'd1 << 48;
                    div_den_reg <= 30'(span) * 30'(rate_reg);
                end
                default:
                begin
                    div_num_reg <= {fhz, 32'd0};
                    div_den_reg <= 30'(rate_reg);
                end
            endcase
        end
        if (cmd.sum)
        begin
            l_sum_reg <= l_sum;
            r_sum_reg <= r_sum;
        end
        if (cmd.capture)
        begin
            l_res_reg <= '0;
            r_res_reg <= '0;
        end
        else if (cmd.mul)
        begin
            l_res_reg <= l_prod[19:5];
            r_res_reg <= r_prod[19:5];
        end
        if (cmd.emit)
            m_tdata_reg <= {1'b0, any_voice_on_reg, r_res_reg, l_res_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    fvpsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sts.rate_zero = (rate_reg == '0);
    assign sts.active    = any_voice_on_reg;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> any_voice_on_reg)
        else $error("voice state advanced while silent");

    a_active_master: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(any_voice_on_reg) |-> master_on_reg)
        else $error("voice active without master enable");

endmodule
`default_nettype wire

// File: src/fvpsg_ctrl.sv
// Sequencer: decodes request beats and steps the datapath through each request.
`default_nettype none
module fvpsg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [1:0]       s_tuser,
    input  wire fvpsg_pkg::sts_t  sts,
    output fvpsg_pkg::cmd_t       cmd
);

    fvpsg_pkg::state_t   state_reg, state_next;
    fvpsg_pkg::div_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fvpsg_pkg::ST_IDLE;
            sel_reg   <= fvpsg_pkg::DIV_SQ0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            fvpsg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        fvpsg_pkg::REQ_WRITE:
                            cmd.wr = 1'b1;
                        fvpsg_pkg::REQ_BEGIN:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = sts.rate_zero ? fvpsg_pkg::ST_EMIT
                                                        : fvpsg_pkg::ST_BB_SETUP;
                        end
                        fvpsg_pkg::REQ_SAMPLE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = sts.active ? fvpsg_pkg::ST_SMP_STEP
                                                     : fvpsg_pkg::ST_EMIT;
                        end
                        // drop a beat of unknown kind
                        default: ;
                    endcase
                end
            end
            fvpsg_pkg::ST_BB_SETUP:
            begin
                cmd.setup  = 1'b1;
                sel_next   = fvpsg_pkg::DIV_SQ0;
                state_next = fvpsg_pkg::ST_DIV_LOAD;
            end
            fvpsg_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = fvpsg_pkg::ST_DIV_START;
            end
            fvpsg_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = fvpsg_pkg::ST_DIV_WAIT;
            end
            fvpsg_pkg::ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    unique case (sel_reg)
                        fvpsg_pkg::DIV_SQ0:  sel_next = fvpsg_pkg::DIV_SQ1;
                        fvpsg_pkg::DIV_SQ1:  sel_next = fvpsg_pkg::DIV_WAVE;
                        fvpsg_pkg::DIV_WAVE: sel_next = fvpsg_pkg::DIV_NOISE;
                        default:             sel_next = fvpsg_pkg::DIV_SQ0;
                    endcase
                    state_next = (sel_reg == fvpsg_pkg::DIV_NOISE) ? fvpsg_pkg::ST_BB_FLAG
                                                                   : fvpsg_pkg::ST_DIV_LOAD;
                end
            end
            fvpsg_pkg::ST_BB_FLAG:
            begin
                cmd.flag   = 1'b1;
                state_next = fvpsg_pkg::ST_EMIT;
            end
            fvpsg_pkg::ST_SMP_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = fvpsg_pkg::ST_SMP_SUM;
            end
            fvpsg_pkg::ST_SMP_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = fvpsg_pkg::ST_SMP_MUL;
            end
            fvpsg_pkg::ST_SMP_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = fvpsg_pkg::ST_EMIT;
            end
            fvpsg_pkg::ST_EMIT:
            begin
                // hold until the output beat slot is free
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = fvpsg_pkg::ST_IDLE;
                end
            end
            default:
                state_next = fvpsg_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: src/four_voice_psg_synthesizer.sv
// Top level: four-voice sound generator with request stream in and sample stream out.
// Write beat: updates the register window, no result. Sample beat: state step, mix sum,
// scale multiply, then output register; output register alone when no voice is active.
// Begin beat: setup, four increments in turn through one shared 52-step divider, voice
// flag and output register. Sample rate zero sends a begin beat straight to the output
// register. One request in flight at a time; the output register holds a result while
// the next request is accepted. Reset (rst_n low, asynchronous) clears the window and
// voices and returns the sample rate to 32768.
`default_nettype none
module four_voice_psg_synthesizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_offset[5:0], reg_data[13:6], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // left_sample[14:0], right_sample[29:15],
                                        // voice_active[30], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [17:0] cfg_data   // sample_rate
);

    fvpsg_pkg::cmd_t cmd;
    fvpsg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fvpsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    fvpsg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
